// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, forces a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/kvtu_pkg.sv =====
// ----------------------------------------------------------------------------
// kvtu_pkg
// Types and constants shared by the key/value table upsert unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvtu_pkg;

  // Default number of table entries.
  localparam int CAPACITY = 64;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Request operation codes.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_UPSERT = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    func_t              func;
    logic               scan;    // Needs a search for the oldest matching key.
    logic               append;  // Appends a pair when no entry matches.
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/kvtu_front.sv =====
// ----------------------------------------------------------------------------
// kvtu_front
// Accepts request items, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvtu_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic signed [kvtu_pkg::KEY_W-1:0] in_key,
  input  wire logic [kvtu_pkg::VAL_W-1:0]    in_value_in,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output kvtu_pkg::cmd_t                     cmd
);

  localparam int QDEPTH = 2;

  kvtu_pkg::cmd_t q_r [QDEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  kvtu_pkg::cmd_t dec;
  logic           push, pop;

  // Decode the operation into the flags the back end acts on.
  always_comb begin
    dec.func   = kvtu_pkg::func_t'(in_func);
    dec.scan   = 1'b0;
    dec.append = 1'b0;
    dec.key    = in_key;
    dec.value  = in_value_in;
    case (dec.func)
      kvtu_pkg::FUNC_INSERT: begin
        dec.append = 1'b1;
      end
      kvtu_pkg::FUNC_GET: begin
        dec.scan = 1'b1;
      end
      kvtu_pkg::FUNC_UPSERT: begin
        dec.scan   = 1'b1;
        dec.append = 1'b1;
      end
      default: begin
        dec.scan   = 1'b0;
        dec.append = 1'b0;
      end
    endcase
  end

  // Two-entry queue between the input channel and the back end.
  assign in_ready  = (fill_r != 2'(QDEPTH));
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== design/kvtu_back.sv =====
// ----------------------------------------------------------------------------
// kvtu_back
// Executes queued requests against the key and value memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvtu_back #(
  parameter int CAPACITY = kvtu_pkg::CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire kvtu_pkg::cmd_t                cmd,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [kvtu_pkg::VAL_W-1:0]         out_value_out,
  output logic                               out_dropped,
  output logic [$clog2(CAPACITY+1)-1:0]      sts_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Entry storage: one write port, one registered read port.
  logic [kvtu_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [kvtu_pkg::VAL_W-1:0] val_mem [CAPACITY];
  logic [kvtu_pkg::KEY_W-1:0] key_rd_r;
  logic [kvtu_pkg::VAL_W-1:0] val_rd_r;
  logic                       key_we, val_we;
  logic [AW-1:0]              wr_addr;

  state_t                     state_r, state_nxt;
  kvtu_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]              chk_idx_r, chk_idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [kvtu_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic                       out_dropped_r, out_dropped_nxt;
  logic                       miss_go;
  logic                       table_full;

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_value_out = out_value_r;
  assign out_dropped   = out_dropped_r;
  assign sts_count     = count_r;
  assign table_full    = (count_r == CAP_CNT);

  // Sequencer: take a request, search oldest-first if it scans, then write or clear and report.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    count_nxt       = count_r;
    rd_ptr_nxt      = rd_ptr_r;
    chk_vld_nxt     = chk_vld_r;
    chk_idx_nxt     = chk_idx_r;
    out_valid_nxt   = out_valid_r;
    out_found_nxt   = out_found_r;
    out_value_nxt   = out_value_r;
    out_dropped_nxt = out_dropped_r;
    key_we          = 1'b0;
    val_we          = 1'b0;
    wr_addr         = count_r[AW-1:0];
    cmd_ready       = 1'b0;
    miss_go         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // Only start once the result register is free, so a finish never stalls.
        cmd_ready = !out_valid_r;
        if (cmd_valid && !out_valid_r) begin
          cmd_nxt   = cmd;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_r.func == kvtu_pkg::FUNC_CLEAR) begin
          count_nxt       = '0;
          out_valid_nxt   = 1'b1;
          out_found_nxt   = 1'b0;
          out_value_nxt   = '0;
          out_dropped_nxt = 1'b0;
          state_nxt       = ST_IDLE;
        end else if (cmd_r.scan && (count_r != '0)) begin
          rd_ptr_nxt  = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end else begin
          miss_go = 1'b1;
        end
      end
      ST_SCAN: begin
        if (chk_vld_r && (key_rd_r == cmd_r.key)) begin
          // Oldest match found; upsert overwrites its value.
          out_valid_nxt   = 1'b1;
          out_found_nxt   = 1'b1;
          out_value_nxt   = val_rd_r;
          out_dropped_nxt = 1'b0;
          if (cmd_r.func == kvtu_pkg::FUNC_UPSERT) begin
            val_we  = 1'b1;
            wr_addr = chk_idx_r;
          end
          state_nxt = ST_IDLE;
        end else if (rd_ptr_r != count_r) begin
          rd_ptr_nxt  = rd_ptr_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_ptr_r[AW-1:0];
        end else begin
          miss_go = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // No match: append when the operation calls for it and the table has room (else flag a drop); report a miss.
    if (miss_go) begin
      out_valid_nxt   = 1'b1;
      out_found_nxt   = 1'b0;
      out_value_nxt   = '0;
      out_dropped_nxt = 1'b0;
      if (cmd_r.append) begin
        if (table_full) begin
          out_dropped_nxt = 1'b1;
        end else begin
          key_we    = 1'b1;
          val_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    rd_ptr_r      <= rd_ptr_nxt;
    chk_idx_r     <= chk_idx_nxt;
    out_found_r   <= out_found_nxt;
    out_value_r   <= out_value_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  // Memory ports: the read address follows the scan pointer every cycle.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= cmd_r.key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= cmd_r.value;
    end
    key_rd_r <= key_mem[rd_ptr_r[AW-1:0]];
    val_rd_r <= val_mem[rd_ptr_r[AW-1:0]];
  end

endmodule

`default_nettype wire

// ===== design/key_value_table_upsert_unit.sv =====
// Key/value table upsert unit.
// Input channel (in_valid/in_ready) takes one request item: in_func selects
// insert, get, upsert or clear, with in_key and in_value_in as operands.
// Output channel (out_valid/out_ready) returns exactly one result item per
// request: out_found, out_value_out and out_dropped, in request order.
// Entries are kept oldest first; get and upsert act on the oldest match.
// Insert, clear, and get or upsert on an empty table finish without a search.
// A search reads the key memory through its single read port one entry per
// cycle, oldest first, and stops at the first match; the engine works on one
// request at a time.
// A two-entry request queue keeps accepting items while the engine works or
// while a result waits in the output register.
// When the receiver stalls, the result holds and the engine waits for it to
// be taken before starting the next request.
// Reset empties the table and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_value_table_upsert_unit
// Top level: request queue front end and table search/update back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module key_value_table_upsert_unit #(
  parameter int CAPACITY = kvtu_pkg::CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_func,
  input  wire logic signed [kvtu_pkg::KEY_W-1:0] in_key,
  input  wire logic [kvtu_pkg::VAL_W-1:0]        in_value_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_found,
  output logic [kvtu_pkg::VAL_W-1:0]             out_value_out,
  output logic                                   out_dropped
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic           cmd_valid;
  logic           cmd_ready;
  kvtu_pkg::cmd_t cmd;
  logic [CW-1:0]  sts_count;

  // Request decode and queue.
  kvtu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_key      (in_key),
    .in_value_in (in_value_in),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  // Table storage, search and result register.
  kvtu_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_value_out (out_value_out),
    .out_dropped   (out_dropped),
    .sts_count     (sts_count)
  );

  // Checks on the table and the result path.
  `ASSERT_ALWAYS(a_count_bound, sts_count <= CW'(CAPACITY), "entry count exceeds capacity")
  `ASSERT_IMPLIES(a_found_not_dropped, out_valid && out_found, !out_dropped, "found and dropped together")
  `ASSERT_IMPLIES(a_miss_zero, out_valid && !out_found, out_value_out == '0, "miss with nonzero value")
  `ASSERT_IMPLIES(a_pop_free, cmd_valid && cmd_ready, !out_valid, "request taken while result pending")

endmodule

`default_nettype wire
